### rtl/core/lzgbp_pkg.sv
package lzgbp_pkg;

  localparam int POS_W  = 24;
  localparam int LEN_W  = 16;
  localparam int OFF_W  = 15;
  localparam int LIT_W  = 8;
  localparam int HI_W   = 9;
  localparam int K_W    = 4;
  localparam int PC_W   = 4;

  localparam logic [OFF_W-1:0] WINDOW_LIMIT = 15'd32640;
  localparam logic [LEN_W-1:0] END_MARKER   = 16'd256;

  typedef enum logic [1:0] {
    OP_HDR   = 2'd0,
    OP_LIT   = 2'd1,
    OP_MATCH = 2'd2,
    OP_END   = 2'd3
  } op_t;

  // source of the bit that goes into the stream this step
  typedef enum logic [2:0] {
    BIT_NONE,
    BIT_ZERO,
    BIT_ONE,
    BIT_GZ,   // gamma marker: 0 while digits remain, final 1 when none left
    BIT_GD    // gamma digit, inverted when the gamma is inverted
  } bit_src_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD_LEN,
    ACT_LOAD_HI,
    ACT_LOAD_END,
    ACT_LOW,
    ACT_LIT,
    ACT_FLUSH,
    ACT_DONE,
    ACT_END_DONE
  } act_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_KZ
  } cond_t;

  typedef struct packed {
    bit_src_t          bsrc;
    act_t              act;
    cond_t             cond;
    logic              last;
    logic [PC_W-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic   step;
    ucode_t uw;
  } ctrl_t;

  typedef struct packed {
    logic k_zero;
    logic out_block;
    logic started;
    logic repeat_hit;
  } status_t;

  localparam logic [PC_W-1:0] UA_HDR      = 4'd0;
  localparam logic [PC_W-1:0] UA_HDR_GZ   = 4'd1;
  localparam logic [PC_W-1:0] UA_LIT      = 4'd3;
  localparam logic [PC_W-1:0] UA_NEWM     = 4'd4;
  localparam logic [PC_W-1:0] UA_HI_GZ    = 4'd5;
  localparam logic [PC_W-1:0] UA_LOW      = 4'd7;
  localparam logic [PC_W-1:0] UA_LEN_GZ   = 4'd8;
  localparam logic [PC_W-1:0] UA_END      = 4'd10;
  localparam logic [PC_W-1:0] UA_END_GZ   = 4'd11;
  localparam logic [PC_W-1:0] UA_FLUSH    = 4'd13;
  localparam logic [PC_W-1:0] UA_END_DONE = 4'd14;
  localparam logic [PC_W-1:0] UA_DONE     = 4'd15;

  function automatic ucode_t mk_uw(input bit_src_t bsrc, input act_t act, input cond_t cond,
                                   input logic last, input logic [PC_W-1:0] target);
    ucode_t w;
    w.bsrc   = bsrc;
    w.act    = act;
    w.cond   = cond;
    w.last   = last;
    w.target = target;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    case (addr)
      4'd0:  w = mk_uw(BIT_ZERO, ACT_LOAD_LEN, COND_NEXT,   1'b0, UA_DONE);
      4'd1:  w = mk_uw(BIT_GZ,   ACT_NONE,     COND_KZ,     1'b0, UA_DONE);
      4'd2:  w = mk_uw(BIT_GD,   ACT_NONE,     COND_ALWAYS, 1'b0, UA_HDR_GZ);
      4'd3:  w = mk_uw(BIT_NONE, ACT_LIT,      COND_ALWAYS, 1'b0, UA_DONE);
      4'd4:  w = mk_uw(BIT_ONE,  ACT_LOAD_HI,  COND_NEXT,   1'b0, UA_DONE);
      4'd5:  w = mk_uw(BIT_GZ,   ACT_NONE,     COND_KZ,     1'b0, UA_LOW);
      4'd6:  w = mk_uw(BIT_GD,   ACT_NONE,     COND_ALWAYS, 1'b0, UA_HI_GZ);
      4'd7:  w = mk_uw(BIT_NONE, ACT_LOW,      COND_NEXT,   1'b0, UA_DONE);
      4'd8:  w = mk_uw(BIT_GZ,   ACT_NONE,     COND_KZ,     1'b0, UA_DONE);
      4'd9:  w = mk_uw(BIT_GD,   ACT_NONE,     COND_ALWAYS, 1'b0, UA_LEN_GZ);
      4'd10: w = mk_uw(BIT_ONE,  ACT_LOAD_END, COND_NEXT,   1'b0, UA_DONE);
      4'd11: w = mk_uw(BIT_GZ,   ACT_NONE,     COND_KZ,     1'b1, UA_FLUSH);
      4'd12: w = mk_uw(BIT_GD,   ACT_NONE,     COND_ALWAYS, 1'b0, UA_END_GZ);
      4'd13: w = mk_uw(BIT_NONE, ACT_FLUSH,    COND_NEXT,   1'b0, UA_DONE);
      4'd14: w = mk_uw(BIT_NONE, ACT_END_DONE, COND_NEXT,   1'b0, UA_DONE);
      4'd15: w = mk_uw(BIT_NONE, ACT_DONE,     COND_NEXT,   1'b0, UA_DONE);
      default: w = mk_uw(BIT_NONE, ACT_DONE,   COND_NEXT,   1'b0, UA_DONE);
    endcase
    return w;
  endfunction

endpackage

### rtl/core/lzgbp_sequencer.sv
module lzgbp_sequencer
  import lzgbp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  op_t     op,
  input  status_t status,
  output logic    busy,
  output ctrl_t   ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] entry;
  ucode_t          uw;
  logic            go;
  logic            take_jump;

  assign uw = ucode_rom(pc);
  assign go = busy && !status.out_block;
  assign take_jump = (uw.cond == COND_ALWAYS) || ((uw.cond == COND_KZ) && status.k_zero);

  // dispatch on the token kind
  always_comb begin
    case (op)
      OP_HDR:   entry = UA_HDR;
      OP_LIT:   entry = UA_LIT;
      OP_MATCH: entry = status.repeat_hit ? UA_HDR : UA_NEWM;
      OP_END:   entry = status.started ? UA_END : UA_END_DONE;
      default:  entry = UA_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= UA_DONE;
    end else if (accept) begin
      busy <= 1'b1;
      pc   <= entry;
    end else if (go) begin
      if (uw.act == ACT_DONE || uw.act == ACT_END_DONE) begin
        busy <= 1'b0;
      end else if (take_jump) begin
        pc <= uw.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  assign ctrl.step = go;
  assign ctrl.uw   = uw;

endmodule

### rtl/core/lzgbp_datapath.sv
module lzgbp_datapath
  import lzgbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  op_t              op,
  input  logic [LEN_W-1:0] run_length,
  input  logic [OFF_W-1:0] match_offset,
  input  logic [LIT_W-1:0] literal_byte,
  input  ctrl_t            ctrl,
  output status_t          status,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POS_W-1:0] out_position,
  output logic [7:0]       out_data,
  output logic             out_last
);

  // token operands
  logic [LEN_W-1:0] len_r;
  logic [OFF_W-1:0] off_r;
  logic [LIT_W-1:0] lit_r;
  logic [OFF_W-1:0] off_clamped;
  logic [OFF_W-1:0] off_m1;
  logic [HI_W-1:0]  off_hi;

  // stream state
  logic [POS_W-1:0] next_pos, next_pos_next;
  logic [POS_W-1:0] holder_pos, holder_pos_next;
  logic [7:0]       holder_val, holder_val_next;
  logic [7:0]       bit_mask, bit_mask_next;
  logic [OFF_W-1:0] prev_off, prev_off_next;
  logic             drop, drop_next;
  logic             started, started_next;
  logic             low_pending, low_pending_next;
  logic [POS_W-1:0] low_pos, low_pos_next;
  logic [7:0]       low_val, low_val_next;

  // gamma unit
  logic [LEN_W-1:0] gval, gval_next;
  logic [K_W-1:0]   gk, gk_next;
  logic             ginv, ginv_next;
  logic             k_zero;
  logic [LEN_W-1:0] load_val;
  logic             load_inv;
  logic             load_en;

  logic             bit_en;
  logic             bit_val;
  logic             opening;
  logic [7:0]       mask_cur;
  logic [7:0]       hval_new;
  logic [7:0]       mask_new;

  logic             emit_en;
  logic [POS_W-1:0] emit_pos;
  logic [7:0]       emit_data;
  logic             emit_last;

  function automatic logic [K_W-1:0] top_bit(input logic [LEN_W-1:0] v);
    logic [K_W-1:0] t;
    t = '0;
    for (int i = 1; i < LEN_W; i++) begin
      if (v[i]) t = K_W'(i);
    end
    return t;
  endfunction

  always_comb begin
    if (match_offset == '0) begin
      off_clamped = OFF_W'(1);
    end else if (match_offset > WINDOW_LIMIT) begin
      off_clamped = WINDOW_LIMIT;
    end else begin
      off_clamped = match_offset;
    end
  end

  assign off_m1 = off_r - 1'b1;
  assign off_hi = HI_W'(off_m1[OFF_W-1:7]) + 1'b1;
  assign k_zero = (gk == '0);

  assign status.k_zero     = k_zero;
  assign status.out_block  = out_valid && !out_ready;
  assign status.started    = started;
  assign status.repeat_hit = (off_clamped == prev_off);

  // gamma load selection
  always_comb begin
    load_en  = ctrl.step;
    load_val = len_r;
    load_inv = 1'b0;
    case (ctrl.uw.act)
      ACT_LOAD_LEN: begin
        load_val = len_r;
      end
      ACT_LOAD_HI: begin
        load_val = LEN_W'(off_hi);
        load_inv = 1'b1;
      end
      ACT_LOAD_END: begin
        load_val = END_MARKER;
        load_inv = 1'b1;
      end
      ACT_LOW: begin
        load_val = (len_r == '0) ? '0 : len_r - 1'b1;
      end
      default: begin
        load_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    bit_en  = ctrl.step && (ctrl.uw.bsrc != BIT_NONE);
    case (ctrl.uw.bsrc)
      BIT_ONE: bit_val = 1'b1;
      BIT_GZ:  bit_val = k_zero;
      BIT_GD:  bit_val = gval[gk - 1'b1] ^ ginv;
      default: bit_val = 1'b0;
    endcase
  end

  assign opening  = (bit_mask == '0);
  assign mask_cur = opening ? 8'h80 : bit_mask;
  assign hval_new = (opening ? 8'h00 : holder_val) | (bit_val ? mask_cur : 8'h00);
  assign mask_new = mask_cur >> 1;

  always_comb begin
    next_pos_next    = next_pos;
    holder_pos_next  = holder_pos;
    holder_val_next  = holder_val;
    bit_mask_next    = bit_mask;
    prev_off_next    = prev_off;
    drop_next        = drop;
    started_next     = started;
    low_pending_next = low_pending;
    low_pos_next     = low_pos;
    low_val_next     = low_val;
    gval_next        = gval;
    gk_next          = gk;
    ginv_next        = ginv;
    emit_en          = 1'b0;
    emit_pos         = holder_pos;
    emit_data        = holder_val;
    emit_last        = 1'b0;

    if (accept && op != OP_END) begin
      started_next = 1'b1;
    end

    if (load_en) begin
      gval_next = load_val;
      gk_next   = top_bit(load_val);
      ginv_next = load_inv;
    end else if (ctrl.step && ctrl.uw.bsrc == BIT_GD) begin
      gk_next = gk - 1'b1;
    end

    if (bit_en) begin
      if (drop) begin
        drop_next = 1'b0;
      end else if (low_pending) begin
        // first bit after a new offset lands in bit 0 of the offset low byte
        low_pending_next = 1'b0;
        emit_en          = 1'b1;
        emit_pos         = low_pos;
        emit_data        = {low_val[7:1], bit_val};
      end else begin
        if (opening) begin
          holder_pos_next = next_pos;
          next_pos_next   = next_pos + 1'b1;
        end
        holder_val_next = hval_new;
        bit_mask_next   = mask_new;
        if (mask_new == '0) begin
          emit_en   = 1'b1;
          emit_pos  = opening ? next_pos : holder_pos;
          emit_data = hval_new;
          emit_last = ctrl.uw.last && k_zero;
        end
      end
    end

    if (ctrl.step) begin
      case (ctrl.uw.act)
        ACT_LIT: begin
          emit_en       = 1'b1;
          emit_pos      = next_pos;
          emit_data     = lit_r;
          next_pos_next = next_pos + 1'b1;
        end
        ACT_LOW: begin
          low_pos_next     = next_pos;
          low_val_next     = {~off_m1[6:0], 1'b0};
          low_pending_next = 1'b1;
          next_pos_next    = next_pos + 1'b1;
          prev_off_next    = off_r;
        end
        ACT_FLUSH: begin
          if (bit_mask != '0) begin
            emit_en   = 1'b1;
            emit_pos  = holder_pos;
            emit_data = holder_val;
            emit_last = 1'b1;
          end
        end
        ACT_END_DONE: begin
          next_pos_next    = '0;
          holder_pos_next  = '0;
          holder_val_next  = '0;
          bit_mask_next    = '0;
          prev_off_next    = OFF_W'(1);
          drop_next        = 1'b1;
          started_next     = 1'b0;
          low_pending_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_pos    <= '0;
      holder_pos  <= '0;
      holder_val  <= '0;
      bit_mask    <= '0;
      prev_off    <= OFF_W'(1);
      drop        <= 1'b1;
      started     <= 1'b0;
      low_pending <= 1'b0;
      gk          <= '0;
      out_valid   <= 1'b0;
    end else begin
      next_pos    <= next_pos_next;
      holder_pos  <= holder_pos_next;
      holder_val  <= holder_val_next;
      bit_mask    <= bit_mask_next;
      prev_off    <= prev_off_next;
      drop        <= drop_next;
      started     <= started_next;
      low_pending <= low_pending_next;
      gk          <= gk_next;
      if (emit_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_pos <= low_pos_next;
    low_val <= low_val_next;
    gval    <= gval_next;
    ginv    <= ginv_next;
    if (accept) begin
      len_r <= run_length;
      off_r <= off_clamped;
      lit_r <= literal_byte;
    end
    if (emit_en) begin
      out_position <= emit_pos;
      out_data     <= emit_data;
      out_last     <= emit_last;
    end
  end

endmodule

### rtl/core/lz_gamma_bitstream_packer_core.sv
// lz gamma bitstream packer: turns a chosen parse, one token per beat, into the
// compressed byte stream as (position, byte) writes.
// input channel s_axis: tuser is the token kind (run header, literal byte,
// match, end); tdata carries length, offset and literal byte.
// output channel m_axis: one beat per finished byte; tlast marks the final
// write caused by an end token. writes of one token come out in the order the
// bytes are completed, so a holder byte may follow a byte at a later position.
// the core takes one token at a time; tready is low while a token runs.
// a microcoded sequencer moves one gamma bit per cycle unless the output stalls;
// a gamma with n significant bits is 2n-1 stream bits. a new-offset match sends
// the inverted gamma of the high offset part, the low offset byte and the gamma
// of length-1; a literal byte is written straight out.
// a result sits in the output register until taken; while it waits, the
// sequencer holds its current step, so a stall never drops or repeats a byte.
// reset (rst, synchronous) starts a fresh stream at position 0 with the last
// offset set to 1; the end token brings the core back to that same state.
module lz_gamma_bitstream_packer_core
  import lzgbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // run_length[15:0], match_offset[30:16], literal_byte[38:31]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // position[23:0], data[31:24]
  output logic        m_axis_tlast
);

  logic             accept;
  logic             busy;
  op_t              op;
  ctrl_t            ctrl;
  status_t          status;
  logic [POS_W-1:0] out_position;
  logic [7:0]       out_data;

  assign op            = op_t'(s_axis_tuser);
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;

  lzgbp_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (op),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  lzgbp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op           (op),
    .run_length   (s_axis_tdata[15:0]),
    .match_offset (s_axis_tdata[30:16]),
    .literal_byte (s_axis_tdata[38:31]),
    .ctrl         (ctrl),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_position (out_position),
    .out_data     (out_data),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {out_data, out_position};

endmodule

### sim/tb.sv
module tb;
  import lzgbp_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // run_length[15:0], match_offset[30:16], literal_byte[38:31]
  logic [1:0]  s_axis_tuser = OP_HDR; // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // position[23:0], data[31:24]
  logic        m_axis_tlast;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic             last;
  } byte_write_t;

  class gamma_stream_board;
    byte_write_t      pending_writes[$];
    int               errors;
    int               checked;
    logic [POS_W-1:0] next_pos;
    logic [POS_W-1:0] hold_pos;
    logic [7:0]       hold_val;
    logic [7:0]       bit_mask;
    logic [OFF_W-1:0] last_off;
    bit               skip_bit;
    bit               started;
    bit               low_open;
    logic [POS_W-1:0] low_pos;
    logic [7:0]       low_val;
    int               step_writes;

    function new();
      errors = 0;
      checked = 0;
      restart();
    endfunction

    function void restart();
      next_pos = '0;
      hold_pos = '0;
      hold_val = '0;
      bit_mask = '0;
      last_off = OFF_W'(1);
      skip_bit = 1'b1;
      started = 1'b0;
      low_open = 1'b0;
    endfunction

    function void record_write(logic [POS_W-1:0] pos, logic [7:0] data);
      byte_write_t w;
      w.pos = pos;
      w.data = data;
      w.last = 1'b0;
      pending_writes.insert(pending_writes.size(), w);
      step_writes++;
    endfunction

    function void put_stream_bit(bit b);
      if (skip_bit) begin
        skip_bit = 1'b0;
        return;
      end
      // the bit right after a new offset lands in bit 0 of its low byte
      if (low_open) begin
        low_val[0] = b;
        low_open = 1'b0;
        record_write(low_pos, low_val);
        return;
      end
      if (bit_mask == 0) begin
        hold_pos = next_pos;
        next_pos = next_pos + 1'b1;
        hold_val = '0;
        bit_mask = 8'h80;
      end
      if (b) hold_val = hold_val | bit_mask;
      bit_mask = bit_mask >> 1;
      if (bit_mask == 0) record_write(hold_pos, hold_val);
    endfunction

    function void put_gamma_code(logic [31:0] v, bit inv);
      int top;
      top = 0;
      for (int k = 1; k < 32; k++)
        if (v[k]) top = k;
      for (int k = top; k > 0; k--) begin
        put_stream_bit(1'b0);
        put_stream_bit(inv ? !v[k-1] : v[k-1]);
      end
      put_stream_bit(1'b1);
    endfunction

    function void note_token(op_t op, logic [LEN_W-1:0] len, logic [OFF_W-1:0] off_in,
                             logic [7:0] lit);
      logic [OFF_W-1:0] off;
      int               off_m1;
      step_writes = 0;
      low_open = 1'b0;
      off = off_in;
      case (op)
        OP_HDR: begin
          started = 1'b1;
          put_stream_bit(1'b0);
          put_gamma_code(32'(len), 1'b0);
        end
        OP_LIT: begin
          started = 1'b1;
          record_write(next_pos, lit);
          next_pos = next_pos + 1'b1;
        end
        OP_MATCH: begin
          started = 1'b1;
          if (off == 0) off = OFF_W'(1);
          if (off > WINDOW_LIMIT) off = WINDOW_LIMIT;
          if (off == last_off) begin
            put_stream_bit(1'b0);
            put_gamma_code(32'(len), 1'b0);
          end else begin
            off_m1 = off - 1;
            put_stream_bit(1'b1);
            put_gamma_code((off_m1 >> 7) + 1, 1'b1);
            low_pos = next_pos;
            low_val = {~off_m1[6:0], 1'b0};
            next_pos = next_pos + 1'b1;
            low_open = 1'b1;
            put_gamma_code(len > 0 ? len - 1 : 0, 1'b0);
            last_off = off;
          end
        end
        default: begin
          if (started) begin
            put_stream_bit(1'b1);
            put_gamma_code(32'(END_MARKER), 1'b1);
            if (bit_mask != 0) record_write(hold_pos, hold_val);
            if (step_writes > 0) pending_writes[pending_writes.size()-1].last = 1'b1;
          end
          restart();
        end
      endcase
    endfunction

    function void check_write(logic [POS_W-1:0] pos, logic [7:0] data, logic last);
      byte_write_t w;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write pos=%h data=%h last=%b", $time, pos, data, last);
        errors++;
        return;
      end
      w = pending_writes.pop_front();
      checked++;
      if (pos !== w.pos) begin
        $display("%0t: position expected %h got %h", $time, w.pos, pos);
        errors++;
      end
      if (data !== w.data) begin
        $display("%0t: data at %h expected %h got %h", $time, w.pos, w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last at %h expected %b got %b", $time, w.pos, w.last, last);
        errors++;
      end
    endfunction
  endclass

  gamma_stream_board board = new();
  int src_idle_pct = 32;
  int dst_idle_pct = 78;
  int tokens_sent = 0;
  int idle_cycles = 0;

  lz_gamma_bitstream_packer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_write(m_axis_tdata[23:0], m_axis_tdata[31:24], m_axis_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  // valid drops for random idle gaps before a token, else stays high between back-to-back tokens
  task automatic send_token(input op_t op, input logic [LEN_W-1:0] len,
                            input logic [OFF_W-1:0] off, input logic [7:0] lit);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, lit, off, len};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_token(op, len, off, lit);
    tokens_sent++;
  endtask

  function automatic logic [LEN_W-1:0] pick_run();
    int r;
    r = $urandom_range(99);
    if (r < 80) return LEN_W'($urandom_range(1, 8));
    if (r < 95) return LEN_W'($urandom_range(9, 1000));
    return LEN_W'($urandom);
  endfunction

  function automatic logic [OFF_W-1:0] pick_offset();
    int r;
    r = $urandom_range(99);
    if (r < 30) return board.last_off;
    if (r < 60) return OFF_W'($urandom_range(1, 256));
    if (r < 90) return OFF_W'($urandom_range(1, WINDOW_LIMIT));
    return OFF_W'($urandom);
  endfunction

  task automatic send_random_stream();
    int               segs;
    int               n;
    logic [LEN_W-1:0] len;
    // odd tokens and broken streams now and then
    if ($urandom_range(99) < 10) begin
      send_token(op_t'(2'($urandom_range(3))), LEN_W'($urandom), OFF_W'($urandom),
                 8'($urandom));
      return;
    end
    segs = $urandom_range(1, 5);
    for (int s = 0; s < segs; s++) begin
      if (s == 0 || $urandom_range(1)) begin
        len = pick_run();
        send_token(OP_HDR, len, OFF_W'($urandom), 8'($urandom));
        n = (len != 0 && len <= 8) ? int'(len) : int'($urandom_range(1, 4));
        repeat (n) send_token(OP_LIT, LEN_W'($urandom), OFF_W'($urandom), 8'($urandom));
      end
      repeat ($urandom_range(1, 2)) begin
        len = ($urandom_range(99) < 90) ? LEN_W'($urandom_range(2, 30)) : LEN_W'($urandom);
        send_token(OP_MATCH, len, pick_offset(), 8'($urandom));
      end
    end
    if ($urandom_range(99) < 90)
      send_token(OP_END, LEN_W'($urandom), OFF_W'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty stream, then bytes ahead of the first gamma bit
    send_token(OP_END, 16'hFFFF, 15'h7FFF, 8'hFF);
    send_token(OP_LIT, 16'd0, 15'd0, 8'h00);
    send_token(OP_LIT, 16'hFFFF, 15'h7FFF, 8'hFF);
    send_token(OP_HDR, 16'd1, 15'd0, 8'h00);
    send_token(OP_LIT, 16'd0, 15'd0, 8'hA5);
    // repeat of the initial offset, and offset zero taken as one with zero length
    send_token(OP_MATCH, 16'd2, 15'd1, 8'h00);
    send_token(OP_MATCH, 16'd0, 15'd0, 8'h00);
    send_token(OP_HDR, 16'd0, 15'd0, 8'h00);
    // offset beyond the window clamps, then repeats at the limit
    send_token(OP_MATCH, 16'hFFFF, 15'h7FFF, 8'h00);
    send_token(OP_MATCH, 16'd2, WINDOW_LIMIT, 8'h00);
    send_token(OP_MATCH, 16'd0, 15'd128, 8'h00);
    send_token(OP_MATCH, 16'd1, 15'd129, 8'h00);
    send_token(OP_HDR, 16'hFFFF, 15'd0, 8'h00);
    send_token(OP_LIT, 16'd0, 15'd0, 8'h5A);
    send_token(OP_MATCH, 16'h8000, 15'h7FFF, 8'h00);
    send_token(OP_END, 16'd0, 15'd0, 8'h00);
    // a fresh stream after the end, then two ends in a row
    send_token(OP_HDR, 16'd3, 15'd0, 8'h00);
    send_token(OP_LIT, 16'd0, 15'd0, 8'h01);
    send_token(OP_LIT, 16'd0, 15'd0, 8'h80);
    send_token(OP_LIT, 16'd0, 15'd0, 8'h7F);
    send_token(OP_MATCH, 16'd3, 15'd2, 8'h00);
    send_token(OP_END, 16'd0, 15'd0, 8'h00);
    send_token(OP_END, 16'd0, 15'd0, 8'h00);

    while (tokens_sent < 110) send_random_stream();
    src_idle_pct = 78;
    dst_idle_pct = 32;
    while (tokens_sent < 205) send_random_stream();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    while (tokens_sent < 300) send_random_stream();
    send_token(OP_END, 16'd0, 15'd0, 8'h00);
    s_axis_tvalid <= 1'b0;

    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("tb: %0d tokens sent, %0d byte writes checked, %0d mismatches",
             tokens_sent, board.checked, board.errors);
    $display("tb: directed edge tokens, random parses and noise under three stall mixes");
    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
